@@ hdl/ial_pkg.sv @@
// Shared types, token and error codes, and character helpers for the
// indentation-aware lexer. No dependencies.
`default_nettype none

package ial_pkg;

    localparam int STACK_DEPTH = 32;
    localparam int LVL_W       = $clog2(STACK_DEPTH);
    localparam logic [7:0]  COL_MAX  = 8'hFF;
    localparam logic [15:0] LEN_MAX  = 16'hFFFF;
    localparam logic [19:0] LINE_MAX = 20'hFFFFF;

    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_LESS   = 8'h3C;
    localparam logic [7:0] CH_EQUAL  = 8'h3D;
    localparam logic [7:0] CH_GREAT  = 8'h3E;

    typedef enum logic [4:0] {
        K_LPAREN, K_RPAREN, K_COLON, K_PLUS, K_MINUS, K_SLASH, K_STAR,
        K_LESS, K_GREATER, K_EQUAL, K_EQUAL_EQUAL, K_BANG, K_BANG_EQUAL,
        K_AND, K_OR, K_NOT, K_IF, K_ELIF, K_ELSE, K_WHILE, K_PRINT,
        K_IDENT, K_NUMBER, K_NEWLINE, K_INDENT, K_DEDENT, K_EOF, K_ERROR,
        K_CAT, K_OBJ, K_HOM, K_ARROW
    } tok_kind_t;

    typedef enum logic [1:0] {
        ERR_NONE, ERR_CHAR, ERR_INDENT, ERR_LIMIT
    } err_kind_t;

    typedef enum logic [2:0] {
        MODE_LINE    = 3'd0,
        MODE_COMMENT = 3'd1,
        MODE_IDLE    = 3'd2,
        MODE_IDENT   = 3'd3,
        MODE_NUM     = 3'd4,
        MODE_OP      = 3'd5
    } lex_mode_t;

    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_input;
    } src_item_t;

    typedef struct packed {
        logic [4:0]  token_kind;
        logic [31:0] token_start;
        logic [15:0] token_length;
        logic [19:0] line_number;
        logic [1:0]  error_kind;
        logic        last_of_run;
    } tok_item_t;

    // indent stack access from the sequencer
    typedef struct packed {
        logic             wr_en;
        logic [LVL_W-1:0] wr_addr;
        logic [7:0]       wr_data;
        logic             rd_en;
        logic [LVL_W-1:0] rd_addr;
    } stk_cmd_t;

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || c == 8'h5F;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    // head holds the first five bytes, first byte in the low bits
    function automatic tok_kind_t keyword_kind(input logic [39:0] head,
                                               input logic [15:0] len);
        tok_kind_t k;
        k = K_IDENT;
        if (len == 16'd3 && head == 40'h0000646e61) k = K_AND;
        if (len == 16'd2 && head == 40'h000000726f) k = K_OR;
        if (len == 16'd3 && head == 40'h0000746f6e) k = K_NOT;
        if (len == 16'd2 && head == 40'h0000006669) k = K_IF;
        if (len == 16'd4 && head == 40'h0066696c65) k = K_ELIF;
        if (len == 16'd4 && head == 40'h0065736c65) k = K_ELSE;
        if (len == 16'd5 && head == 40'h656c696877) k = K_WHILE;
        if (len == 16'd5 && head == 40'h746e697270) k = K_PRINT;
        if (len == 16'd3 && head == 40'h0000746163) k = K_CAT;
        if (len == 16'd3 && head == 40'h00006a626f) k = K_OBJ;
        if (len == 16'd3 && head == 40'h00006d6f68) k = K_HOM;
        return k;
    endfunction

    function automatic logic [39:0] extend_head(input logic [39:0] head,
                                                input logic [15:0] len,
                                                input logic [7:0]  c);
        logic [39:0] h;
        h = head;
        case (len)
            16'd0:   h[7:0]   = c;
            16'd1:   h[15:8]  = c;
            16'd2:   h[23:16] = c;
            16'd3:   h[31:24] = c;
            16'd4:   h[39:32] = c;
            default: h = head;
        endcase
        return h;
    endfunction

endpackage

`default_nettype wire

@@ hdl/ial_stack.sv @@
// Indent column stack: one synchronous memory, registered read.
// Depends on ial_pkg. Entry zero always reads as column zero.
`default_nettype none

module ial_stack (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire ial_pkg::stk_cmd_t cmd,
    output logic [7:0]             rd_data
);
    import ial_pkg::*;

    logic [7:0] mem [STACK_DEPTH];
    logic [7:0] mem_q_reg;
    logic       rd_zero_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[cmd.wr_addr] <= cmd.wr_data;
        end
        if (cmd.rd_en)
        begin
            mem_q_reg <= mem[cmd.rd_addr];
        end
    end

    // entry zero is never written; its value comes from here
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_zero_reg <= 1'b1;
        end
        else if (cmd.rd_en)
        begin
            rd_zero_reg <= (cmd.rd_addr == '0);
        end
    end

    assign rd_data = rd_zero_reg ? 8'd0 : mem_q_reg;

`ifndef SYNTHESIS
    a_no_wr_zero: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr_en |-> cmd.wr_addr != '0)
        else $error("write to stack entry zero");
    a_no_rw_same: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.wr_en && cmd.rd_en) |-> cmd.wr_addr != cmd.rd_addr)
        else $error("read and write of one stack entry in one cycle");
    a_no_pipe_rw: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd_en |=> !cmd.rd_en)
        else $error("stack reads back to back");
`endif

endmodule

`default_nettype wire

@@ hdl/indent_aware_lexer_top.sv @@
// Indentation-aware lexer top: byte sequencer, lexeme state, token output.
// Depends on ial_pkg and ial_stack.
//
//   channel | direction | handshake          | payload
//   src     | in        | src_valid/src_stall | ial_pkg::src_item_t
//   tok     | out       | tok_valid/tok_stall | ial_pkg::tok_item_t
//   cfg     | in        | cfg_valid/cfg_ready | tab_width, 5 bits
//
// Each byte passes S_EXEC and S_FIN: indentation, comment and in-lexeme bytes
// need no more, other mid-line bytes add S_CHAR, and a line's first real byte or
// the end marker adds S_RCHK and S_CHAR; each popped indent level adds S_RPOP and
// S_RCHK (one stack memory read, one compare). A token waits in a hold slot so the
// last one of a byte can be flagged. The next byte waits until S_IDLE.
// Reset: stack empty at column 0, line 1, offset 0, tab width 8.
// Output stalls hold the sequencer whenever a new token has nowhere to go.
`default_nettype none

module indent_aware_lexer_top (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               src_valid,
    output logic                    src_stall,
    input  wire ial_pkg::src_item_t src_data,
    output logic                    tok_valid,
    input  wire logic               tok_stall,
    output ial_pkg::tok_item_t      tok_data,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [4:0]         cfg_data
);
    import ial_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_EXEC = 6'b000010,
        S_RCHK = 6'b000100,
        S_RPOP = 6'b001000,
        S_CHAR = 6'b010000,
        S_FIN  = 6'b100000
    } state_t;

    state_t           state_reg, state_next;
    lex_mode_t        mode_reg, mode_next;
    logic [4:0]       tab_reg;
    logic [7:0]       c_reg, c_next;
    logic             eoi_reg, eoi_next;
    logic [31:0]      pos_reg, pos_next;
    logic [31:0]      bpos_reg, bpos_next;
    logic [31:0]      tstart_reg, tstart_next;
    logic [15:0]      len_reg, len_next;
    logic [39:0]      head_reg, head_next;
    logic [7:0]       col_reg, col_next;
    logic [19:0]      line_reg, line_next;
    logic [LVL_W-1:0] lvl_reg, lvl_next;
    logic [7:0]       top_reg, top_next;
    logic             hold_valid_reg, hold_valid_next;
    tok_item_t        hold_reg, hold_next;
    logic             tok_valid_reg, tok_valid_next;
    tok_item_t        tok_reg, tok_next;

    stk_cmd_t   stk_cmd;
    logic [7:0] stk_rd_data;

    logic       emit;
    tok_kind_t  em_kind;
    logic [31:0] em_start;
    logic [15:0] em_len;
    err_kind_t  em_err;
    logic       out_free, can_emit;
    logic [8:0] tab_sum;

    ial_stack u_stack (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (stk_cmd),
        .rd_data (stk_rd_data)
    );

    assign src_stall = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign tok_valid = tok_valid_reg;
    assign tok_data  = tok_reg;
    assign out_free  = !tok_valid_reg || !tok_stall;
    assign can_emit  = !hold_valid_reg || out_free;
    assign tab_sum   = {1'b0, col_reg} + {4'd0, tab_reg};

    always_comb
    begin
        state_next  = state_reg;
        mode_next   = mode_reg;
        c_next      = c_reg;
        eoi_next    = eoi_reg;
        pos_next    = pos_reg;
        bpos_next   = bpos_reg;
        tstart_next = tstart_reg;
        len_next    = len_reg;
        head_next   = head_reg;
        col_next    = col_reg;
        line_next   = line_reg;
        lvl_next    = lvl_reg;
        top_next    = top_reg;
        emit        = 1'b0;
        em_kind     = K_ERROR;
        em_start    = pos_reg;
        em_len      = 16'd0;
        em_err      = ERR_NONE;
        stk_cmd     = '0;
        hold_valid_next = hold_valid_reg;
        hold_next       = hold_reg;
        tok_valid_next  = tok_valid_reg && tok_stall;
        tok_next        = tok_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (src_valid)
                begin
                    c_next   = src_data.char_code;
                    eoi_next = src_data.end_of_input;
                    pos_next = bpos_reg;
                    if (!src_data.end_of_input)
                    begin
                        bpos_next = bpos_reg + 32'd1;
                    end
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                if (can_emit)
                begin
                    state_next = S_FIN;
                    if (eoi_reg || mode_reg == MODE_IDENT || mode_reg == MODE_NUM
                        || mode_reg == MODE_OP)
                    begin
                        em_start = tstart_reg;
                        em_len   = len_reg;
                        if (mode_reg == MODE_IDENT)
                        begin
                            em_kind = keyword_kind(head_reg, len_reg);
                        end
                        else if (mode_reg == MODE_NUM)
                        begin
                            em_kind = K_NUMBER;
                        end
                        else
                        begin
                            em_len  = 16'd1;
                            em_kind = (head_reg[7:0] == CH_MINUS) ? K_MINUS :
                                      (head_reg[7:0] == CH_BANG) ? K_BANG : K_EQUAL;
                        end
                    end
                    if (eoi_reg)
                    begin
                        // flush whatever is pending, then settle indentation
                        emit = (mode_reg == MODE_IDENT || mode_reg == MODE_NUM
                                || mode_reg == MODE_OP);
                        mode_next  = MODE_IDLE;
                        state_next = S_RCHK;
                    end
                    else
                    begin
                        case (mode_reg)
                            MODE_LINE:
                            begin
                                if (c_reg == CH_SPACE)
                                begin
                                    if (col_reg != COL_MAX) col_next = col_reg + 8'd1;
                                end
                                else if (c_reg == CH_TAB)
                                begin
                                    col_next = tab_sum[8] ? COL_MAX : tab_sum[7:0];
                                end
                                else if (c_reg == CH_CR)
                                begin
                                    col_next = col_reg;
                                end
                                else if (c_reg == CH_NL)
                                begin
                                    if (line_reg != LINE_MAX) line_next = line_reg + 20'd1;
                                    col_next = 8'd0;
                                end
                                else if (c_reg == CH_HASH)
                                begin
                                    col_next  = 8'd0;
                                    mode_next = MODE_COMMENT;
                                end
                                else
                                begin
                                    state_next = S_RCHK;
                                end
                            end
                            MODE_COMMENT:
                            begin
                                if (c_reg == CH_NL)
                                begin
                                    if (line_reg != LINE_MAX) line_next = line_reg + 20'd1;
                                    col_next  = 8'd0;
                                    mode_next = MODE_LINE;
                                end
                            end
                            MODE_IDENT, MODE_NUM:
                            begin
                                if (is_digit(c_reg) || (mode_reg == MODE_IDENT
                                    && is_alpha(c_reg)))
                                begin
                                    head_next = extend_head(head_reg, len_reg, c_reg);
                                    if (len_reg != LEN_MAX) len_next = len_reg + 16'd1;
                                end
                                else
                                begin
                                    emit       = 1'b1;
                                    state_next = S_CHAR;
                                end
                            end
                            MODE_OP:
                            begin
                                emit = 1'b1;
                                if (head_reg[7:0] == CH_MINUS && c_reg == CH_GREAT)
                                begin
                                    em_kind = K_ARROW;
                                    em_len  = 16'd2;
                                    mode_next = MODE_IDLE;
                                end
                                else if (head_reg[7:0] == CH_BANG && c_reg == CH_EQUAL)
                                begin
                                    em_kind = K_BANG_EQUAL;
                                    em_len  = 16'd2;
                                    mode_next = MODE_IDLE;
                                end
                                else if (head_reg[7:0] == CH_EQUAL && c_reg == CH_EQUAL)
                                begin
                                    em_kind = K_EQUAL_EQUAL;
                                    em_len  = 16'd2;
                                    mode_next = MODE_IDLE;
                                end
                                else
                                begin
                                    state_next = S_CHAR;
                                end
                            end
                            default:
                            begin
                                state_next = S_CHAR;
                            end
                        endcase
                    end
                end
            end

            S_RCHK:
            begin
                if (can_emit)
                begin
                    state_next = S_CHAR;
                    if (col_reg > top_reg)
                    begin
                        emit = 1'b1;
                        if (lvl_reg == LVL_W'(STACK_DEPTH - 1))
                        begin
                            em_kind  = K_ERROR;
                            em_err   = ERR_LIMIT;
                            col_next = top_reg;
                        end
                        else
                        begin
                            em_kind         = K_INDENT;
                            stk_cmd.wr_en   = 1'b1;
                            stk_cmd.wr_addr = lvl_reg + 1'b1;
                            stk_cmd.wr_data = col_reg;
                            lvl_next        = lvl_reg + 1'b1;
                            top_next        = col_reg;
                        end
                    end
                    else if (col_reg < top_reg)
                    begin
                        if (lvl_reg == '0)
                        begin
                            col_next = top_reg;
                        end
                        else
                        begin
                            stk_cmd.rd_en   = 1'b1;
                            stk_cmd.rd_addr = lvl_reg - 1'b1;
                            lvl_next        = lvl_reg - 1'b1;
                            state_next      = S_RPOP;
                        end
                    end
                end
            end

            S_RPOP:
            begin
                if (can_emit)
                begin
                    emit     = 1'b1;
                    top_next = stk_rd_data;
                    if (col_reg <= stk_rd_data)
                    begin
                        em_kind = K_DEDENT;
                    end
                    else
                    begin
                        em_err = ERR_INDENT;
                    end
                    state_next = S_RCHK;
                end
            end

            S_CHAR:
            begin
                if (can_emit)
                begin
                    state_next = S_FIN;
                    em_len     = 16'd1;
                    mode_next  = MODE_IDLE;
                    if (eoi_reg)
                    begin
                        emit    = 1'b1;
                        em_kind = K_EOF;
                        em_len  = 16'd0;
                    end
                    else if (is_alpha(c_reg) || is_digit(c_reg) || c_reg == CH_MINUS
                             || c_reg == CH_BANG || c_reg == CH_EQUAL)
                    begin
                        mode_next   = is_alpha(c_reg) ? MODE_IDENT :
                                      is_digit(c_reg) ? MODE_NUM : MODE_OP;
                        tstart_next = pos_reg;
                        len_next    = 16'd1;
                        head_next   = {32'd0, c_reg};
                    end
                    else
                    begin
                        emit = 1'b1;
                        case (c_reg)
                            CH_SPACE, CH_CR, CH_TAB: emit    = 1'b0;
                            CH_LPAREN:               em_kind = K_LPAREN;
                            CH_RPAREN:               em_kind = K_RPAREN;
                            CH_COLON:                em_kind = K_COLON;
                            CH_PLUS:                 em_kind = K_PLUS;
                            CH_SLASH:                em_kind = K_SLASH;
                            CH_STAR:                 em_kind = K_STAR;
                            CH_LESS:                 em_kind = K_LESS;
                            CH_GREAT:                em_kind = K_GREATER;
                            CH_NL:
                            begin
                                em_kind   = K_NEWLINE;
                                em_len    = 16'd0;
                                mode_next = MODE_LINE;
                                col_next  = 8'd0;
                                if (line_reg != LINE_MAX) line_next = line_reg + 20'd1;
                            end
                            default:
                            begin
                                em_len = 16'd0;
                                em_err = ERR_CHAR;
                            end
                        endcase
                    end
                end
            end

            S_FIN:
            begin
                if (!hold_valid_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (out_free)
                begin
                    tok_next             = hold_reg;
                    tok_next.last_of_run = 1'b1;
                    tok_valid_next       = 1'b1;
                    hold_valid_next      = 1'b0;
                    state_next           = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // a new token pushes the held one out, known not to be the last
        if (emit)
        begin
            if (hold_valid_reg)
            begin
                tok_next             = hold_reg;
                tok_next.last_of_run = 1'b0;
                tok_valid_next       = 1'b1;
            end
            hold_valid_next        = 1'b1;
            hold_next.token_kind   = em_kind;
            hold_next.token_start  = em_start;
            hold_next.token_length = em_len;
            hold_next.line_number  = line_reg;
            hold_next.error_kind   = em_err;
            hold_next.last_of_run  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            mode_reg       <= MODE_LINE;
            tab_reg        <= 5'd8;
            bpos_reg       <= 32'd0;
            tstart_reg     <= 32'd0;
            len_reg        <= 16'd0;
            head_reg       <= 40'd0;
            col_reg        <= 8'd0;
            line_reg       <= 20'd1;
            lvl_reg        <= '0;
            top_reg        <= 8'd0;
            hold_valid_reg <= 1'b0;
            tok_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            mode_reg       <= mode_next;
            if (cfg_valid && cfg_ready)
            begin
                tab_reg <= cfg_data;
            end
            bpos_reg       <= bpos_next;
            tstart_reg     <= tstart_next;
            len_reg        <= len_next;
            head_reg       <= head_next;
            col_reg        <= col_next;
            line_reg       <= line_next;
            lvl_reg        <= lvl_next;
            top_reg        <= top_next;
            hold_valid_reg <= hold_valid_next;
            tok_valid_reg  <= tok_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        c_reg    <= c_next;
        eoi_reg  <= eoi_next;
        pos_reg  <= pos_next;
        hold_reg <= hold_next;
        tok_reg  <= tok_next;
    end

`ifndef SYNTHESIS
    a_hold_drained: assert property (@(posedge clk) disable iff (!rst_n)
        !(hold_valid_reg && state_reg == S_IDLE))
        else $error("token left in hold slot between bytes");
    a_pop_after_chk: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_RPOP |-> $past(state_reg) == S_RCHK)
        else $error("stack pop without a compare step");
    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        lvl_reg <= LVL_W'(STACK_DEPTH - 1))
        else $error("indent stack level out of range");
    a_fin_last: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN && hold_valid_reg && out_free)
        |=> tok_valid_reg && tok_reg.last_of_run)
        else $error("last token of a byte not flagged");
`endif

endmodule

`default_nettype wire

@@ tb/sv/indent_aware_lexer_top_tb.sv @@
// Self-checking testbench for the indentation-aware lexer top.
// Depends on ial_pkg and the RTL; a local token predictor checks every transfer.
`timescale 1ns / 100ps

module indent_aware_lexer_top_tb;
    import ial_pkg::*;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      src_valid = 1'b0;
    logic      src_stall;
    src_item_t src_data = '0;
    logic      tok_valid;
    logic      tok_stall = 1'b0;
    tok_item_t tok_data;
    logic      cfg_valid = 1'b0;
    logic      cfg_ready;
    logic [4:0] cfg_data = 5'd0;

    indent_aware_lexer_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .src_data  (src_data),
        .tok_valid (tok_valid),
        .tok_stall (tok_stall),
        .tok_data  (tok_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #6 clk = ~clk;

    src_item_t src_pending[$];
    tok_item_t tokens_due[$];
    int        errors = 0;
    bit        quiet = 1'b0;

    // predictor state
    logic [7:0]  ind_stk[STACK_DEPTH];
    int          ind_lvl;
    int          col_cnt;
    logic [19:0] line_cnt;
    logic [31:0] byte_pos;
    logic [31:0] lex_start;
    logic [15:0] lex_len;
    logic [39:0] lex_head;
    lex_mode_t   lex_mode;
    logic [4:0]  tab_w;
    int          step_cnt;

    string     kw_words[11] = '{"and", "or", "not", "if", "elif", "else", "while",
                                "print", "cat", "obj", "hom"};
    tok_kind_t kw_codes[11] = '{K_AND, K_OR, K_NOT, K_IF, K_ELIF, K_ELSE, K_WHILE,
                                K_PRINT, K_CAT, K_OBJ, K_HOM};

    function automatic bit ch_alpha(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic bit ch_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    task automatic put_tok(tok_kind_t k, logic [31:0] s, logic [15:0] l, err_kind_t e);
        if (step_cnt < 64)
        begin
            tokens_due.push_back('{token_kind: k, token_start: s, token_length: l,
                                   line_number: line_cnt, error_kind: e, last_of_run: 1'b0});
            step_cnt++;
        end
    endtask

    task automatic new_line();
        if (line_cnt != LINE_MAX) line_cnt++;
        col_cnt = 0;
    endtask

    function automatic tok_kind_t word_kind();
        logic [39:0] h;
        for (int i = 0; i < 11; i++)
        begin
            h = '0;
            for (int n = 0; n < kw_words[i].len(); n++) h[8*n +: 8] = kw_words[i][n];
            if (lex_len == kw_words[i].len() && lex_head == h) return kw_codes[i];
        end
        return K_IDENT;
    endfunction

    task automatic resolve_column(logic [31:0] pos);
        int top;
        forever
        begin
            top = ind_stk[ind_lvl];
            if (col_cnt == top) break;
            if (col_cnt > top)
            begin
                if (ind_lvl + 1 >= STACK_DEPTH)
                begin
                    put_tok(K_ERROR, pos, 0, ERR_LIMIT);
                    col_cnt = top;
                end
                else
                begin
                    ind_lvl++;
                    ind_stk[ind_lvl] = col_cnt[7:0];
                    put_tok(K_INDENT, pos, 0, ERR_NONE);
                end
                break;
            end
            if (ind_lvl == 0)
            begin
                col_cnt = top;
                break;
            end
            ind_lvl--;
            if (col_cnt <= ind_stk[ind_lvl]) put_tok(K_DEDENT, pos, 0, ERR_NONE);
            else put_tok(K_ERROR, pos, 0, ERR_INDENT);
        end
    endtask

    task automatic start_lexeme(lex_mode_t m, logic [7:0] c, logic [31:0] pos);
        lex_mode  = m;
        lex_start = pos;
        lex_len   = 16'd1;
        lex_head  = {32'd0, c};
    endtask

    task automatic flush_lexeme();
        case (lex_mode)
            MODE_IDENT: put_tok(word_kind(), lex_start, lex_len, ERR_NONE);
            MODE_NUM:   put_tok(K_NUMBER, lex_start, lex_len, ERR_NONE);
            MODE_OP:
                put_tok(lex_head[7:0] == CH_MINUS ? K_MINUS :
                        (lex_head[7:0] == CH_BANG ? K_BANG : K_EQUAL), lex_start, 1, ERR_NONE);
            default: return;
        endcase
        lex_mode = MODE_IDLE;
    endtask

    task automatic idle_byte(logic [7:0] c, logic [31:0] pos);
        lex_mode = MODE_IDLE;
        if (ch_alpha(c)) start_lexeme(MODE_IDENT, c, pos);
        else if (ch_digit(c)) start_lexeme(MODE_NUM, c, pos);
        else
            case (c)
                CH_SPACE, CH_CR, CH_TAB: ;
                CH_MINUS, CH_BANG, CH_EQUAL: start_lexeme(MODE_OP, c, pos);
                CH_LPAREN: put_tok(K_LPAREN, pos, 1, ERR_NONE);
                CH_RPAREN: put_tok(K_RPAREN, pos, 1, ERR_NONE);
                CH_COLON:  put_tok(K_COLON, pos, 1, ERR_NONE);
                CH_PLUS:   put_tok(K_PLUS, pos, 1, ERR_NONE);
                CH_SLASH:  put_tok(K_SLASH, pos, 1, ERR_NONE);
                CH_STAR:   put_tok(K_STAR, pos, 1, ERR_NONE);
                CH_LESS:   put_tok(K_LESS, pos, 1, ERR_NONE);
                CH_GREAT:  put_tok(K_GREATER, pos, 1, ERR_NONE);
                CH_NL:
                begin
                    put_tok(K_NEWLINE, pos, 0, ERR_NONE);
                    new_line();
                    lex_mode = MODE_LINE;
                end
                default:   put_tok(K_ERROR, pos, 0, ERR_CHAR);
            endcase
    endtask

    task automatic predict_tokens(src_item_t it);
        logic [7:0]  c;
        logic [31:0] pos;
        int          n0;
        tok_kind_t   k;
        c = it.char_code;
        pos = byte_pos;
        n0 = tokens_due.size();
        step_cnt = 0;
        if (it.end_of_input)
        begin
            flush_lexeme();
            resolve_column(pos);
            put_tok(K_EOF, pos, 0, ERR_NONE);
            lex_mode = MODE_IDLE;
        end
        else
        begin
            case (lex_mode)
                MODE_LINE:
                    case (c)
                        CH_SPACE: if (col_cnt < 255) col_cnt++;
                        CH_TAB:   col_cnt = (col_cnt + tab_w > 255) ? 255 : col_cnt + tab_w;
                        CH_CR: ;
                        CH_NL:    new_line();
                        CH_HASH:
                        begin
                            col_cnt = 0;
                            lex_mode = MODE_COMMENT;
                        end
                        default:
                        begin
                            resolve_column(pos);
                            idle_byte(c, pos);
                        end
                    endcase
                MODE_COMMENT:
                    if (c == CH_NL)
                    begin
                        new_line();
                        lex_mode = MODE_LINE;
                    end
                MODE_IDENT, MODE_NUM:
                    if (ch_digit(c) || (lex_mode == MODE_IDENT && ch_alpha(c)))
                    begin
                        if (lex_len < 5) lex_head[8*lex_len +: 8] = c;
                        if (lex_len != LEN_MAX) lex_len++;
                    end
                    else
                    begin
                        flush_lexeme();
                        idle_byte(c, pos);
                    end
                MODE_OP:
                begin
                    k = K_LPAREN;
                    if (lex_head[7:0] == CH_MINUS && c == CH_GREAT) k = K_ARROW;
                    else if (lex_head[7:0] == CH_BANG && c == CH_EQUAL) k = K_BANG_EQUAL;
                    else if (lex_head[7:0] == CH_EQUAL && c == CH_EQUAL) k = K_EQUAL_EQUAL;
                    if (k != K_LPAREN)
                    begin
                        put_tok(k, lex_start, 2, ERR_NONE);
                        lex_mode = MODE_IDLE;
                    end
                    else
                    begin
                        flush_lexeme();
                        idle_byte(c, pos);
                    end
                end
                default: idle_byte(c, pos);
            endcase
            byte_pos = pos + 1;
        end
        if (tokens_due.size() > n0) tokens_due[tokens_due.size()-1].last_of_run = 1'b1;
    endtask

    // source driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_valid <= 1'b0;
            src_data  <= '0;
        end
        else if (!src_valid || !src_stall)
        begin
            if (src_pending.size() > 0 && !(!quiet && $urandom_range(0, 99) < 7))
            begin
                src_data  <= src_pending.pop_front();
                src_valid <= 1'b1;
            end
            else
                src_valid <= 1'b0;
        end
    end

    // token sink back-pressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) tok_stall <= 1'b0;
        else tok_stall <= !quiet && ($urandom_range(0, 99) < 7);
    end

    // predict on every source transfer, check every token transfer
    always @(posedge clk)
    begin
        tok_item_t exp_tok;
        if (rst_n)
        begin
            if (src_valid && !src_stall) predict_tokens(src_data);
            if (tok_valid && !tok_stall)
            begin
                if (tokens_due.size() == 0)
                begin
                    $display("%0t unexpected token: expected none, actual %h", $time, tok_data);
                    errors++;
                end
                else
                begin
                    exp_tok = tokens_due.pop_front();
                    if (tok_data !== exp_tok)
                    begin
                        $display("%0t token mismatch: expected %h, actual %h",
                                 $time, exp_tok, tok_data);
                        $display("  kind %0d/%0d start %0d/%0d len %0d/%0d line %0d/%0d",
                                 exp_tok.token_kind, tok_data.token_kind,
                                 exp_tok.token_start, tok_data.token_start,
                                 exp_tok.token_length, tok_data.token_length,
                                 exp_tok.line_number, tok_data.line_number);
                        $display("  err %0d/%0d last %0d/%0d",
                                 exp_tok.error_kind, tok_data.error_kind,
                                 exp_tok.last_of_run, tok_data.last_of_run);
                        errors++;
                    end
                end
            end
        end
    end

    task automatic push_text(string s);
        for (int i = 0; i < s.len(); i++) src_pending.push_back('{char_code: s[i], end_of_input: 1'b0});
    endtask

    task automatic push_end();
        src_pending.push_back('{char_code: 8'($urandom_range(0, 255)), end_of_input: 1'b1});
    endtask

    task automatic drain();
        while (src_pending.size() > 0 || src_valid || tokens_due.size() > 0) @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic write_tab(logic [4:0] v);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        tab_w = v;
        cfg_valid <= 1'b0;
    endtask

    string pieces[37] = '{"if", "elif", "else", "while", "print", "and", "or", "not", "cat",
                          "obj", "hom", "e", "el", "elsee", "whilex", "x1", "_A", "Zq9",
                          "42", "0", "->", "!=", "==", "-", "!", "=", "(", ")", ":", "+",
                          "/", "*", "<", ">", "#", "$", "\r"};

    task automatic random_text(int count);
        int    n;
        string s;
        n = src_pending.size() + count;
        while (src_pending.size() < n)
        begin
            s = "";
            case ($urandom_range(0, 5))
                0: ;
                1: s = "  ";
                2: s = "    ";
                3: s = "\t";
                4: s = " \t ";
                5: s = "      ";
            endcase
            push_text(s);
            if ($urandom_range(0, 19) == 0) push_text("# note");
            else
                repeat ($urandom_range(1, 4))
                begin
                    if ($urandom_range(0, 9) == 0)
                        src_pending.push_back('{char_code: 8'($urandom_range(0, 255)),
                                               end_of_input: 1'b0});
                    else
                        push_text(pieces[$urandom_range(0, 36)]);
                    if ($urandom_range(0, 2) != 0) push_text(" ");
                end
            push_text("\n");
            if ($urandom_range(0, 24) == 0) push_end();
        end
    endtask

    initial
    begin
        foreach (ind_stk[i]) ind_stk[i] = 8'd0;
        ind_lvl = 0;
        col_cnt = 0;
        line_cnt = 20'd1;
        byte_pos = '0;
        lex_start = '0;
        lex_len = '0;
        lex_head = '0;
        lex_mode = MODE_LINE;
        tab_w = 5'd8;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // keywords, operators, mid-line hash, bad indent, stray byte, repeated end
        push_text("if x:\n\tprint 12 #z\n  elif ab->c!=3==4 - !x = y\n   \n# cm\n");
        push_text("else e1 end(a):+/*<>\r\x01\xff\n  q\n    w\n  r\n x\n");
        push_end();
        push_text("z");
        push_end();
        drain();

        // column saturation through tabs
        write_tab(5'd16);
        push_text("\t\t\t\t\t\t\t\t\t\t\t\t\t\t\t\t\tk\nm\n");
        push_text("b");
        push_end();
        drain();

        write_tab(5'd1);
        random_text(45);
        push_end();
        drain();

        quiet = 1'b1;
        write_tab(5'($urandom_range(1, 16)));
        random_text(35);
        push_end();
        drain();
        quiet = 1'b0;

        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        #36_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
